// File: design/anisotropic_diffusion_filter_macros.svh
// assertion macros used by the diffusion filter sequencer
`ifndef ANISOTROPIC_DIFFUSION_FILTER_MACROS_SVH
`define ANISOTROPIC_DIFFUSION_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define ADF_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adf assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define ADF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adf assertion failed");
`else
`define ADF_ASSERT(label, ante, cons)
`define ADF_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: design/adf_pkg.sv
// types and constants of the anisotropic diffusion filter
`timescale 1ns / 1ps
package adf_pkg;

  // pixel and frame geometry
  localparam int PIX_W      = 8;
  localparam int PIX_MAX    = 255;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // configuration registers
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int LAMBDA_W     = 15;
  localparam int CFG_DATA_W   = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int LAMBDA_RESET = 15073;

  // conductance table
  localparam int TBL_DEPTH       = 256;
  localparam int TBL_AW          = $clog2(TBL_DEPTH);
  localparam int COND_W          = 17;
  localparam int COND_FRAC_BITS  = 16;
  localparam int LAMBDA_FRAC_BITS = 16;
  localparam int SHIFT           = LAMBDA_FRAC_BITS + COND_FRAC_BITS;

  // flux arithmetic widths
  localparam int DIFF_W  = PIX_W + 1;
  localparam int TERM_W  = COND_W + 1 + DIFF_W;
  localparam int ACC_W   = TERM_W + 2;
  localparam int MPROD_W = LAMBDA_W + 1 + ACC_W;
  localparam int DELTA_W = MPROD_W - SHIFT;
  localparam int SUM_W   = DELTA_W + 1;

  // neighbours walked per pixel, plus one drain step
  localparam int NB_COUNT = 4;
  localparam int K_W      = $clog2(NB_COUNT + 1);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_TABLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LAMBDA = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    NB_NORTH = 2'd0,
    NB_SOUTH = 2'd1,
    NB_WEST  = 2'd2,
    NB_EAST  = 2'd3
  } nb_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FLUX,
    ST_MUL,
    ST_FIN,
    ST_EMIT_A,
    ST_EMIT_B
  } state_t;

  typedef struct packed {
    logic    clr;
    logic    issue;
    nb_sel_t sel;
    logic    acc;
    logic    mul;
    logic    fin;
  } flux_ctl_t;

endpackage

// File: design/anisotropic_diffusion_filter.sv
// Perona-Malik diffusion pass, four-neighbour, over a raster pixel stream
// Flow: fetch, then for an interior pixel the serial neighbour lookups, multiply and finish, then
// the output register; border pixels skip the lookups, row-1 pixels load no result, and the last
// row loads an extra result. A new pixel or table write is taken only when the sequencer is idle.
// Reset: counters, west tap and result valid clear; sizes and lambda return to 640, 480, 15073.
// Line buffers and conductance table are not cleared and must be written before use.
`timescale 1ns / 1ps
module anisotropic_diffusion_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [adf_pkg::PIX_W-1:0]      in_pixel_in,
  input  logic [adf_pkg::TBL_AW-1:0]     in_table_index,
  input  logic [adf_pkg::COND_W-1:0]     in_table_value,
  input  logic                           cfg_we,
  input  logic [adf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [adf_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_frame_end,
  output logic                           out_run_last
);

  logic                          prev_we, prev_re, prev2_we, prev2_re;
  logic [adf_pkg::COL_W-1:0]     prev_waddr, prev_raddr, prev2_waddr, prev2_raddr;
  logic [adf_pkg::PIX_W-1:0]     prev_wdata, prev_rdata, prev2_wdata, prev2_rdata;
  logic                          tbl_we, tbl_re;
  logic [adf_pkg::TBL_AW-1:0]    tbl_waddr, tbl_raddr;
  logic [adf_pkg::COND_W-1:0]    tbl_wdata, tbl_rdata;
  adf_pkg::flux_ctl_t            flux_ctl;
  logic [adf_pkg::PIX_W-1:0]     cen, north, south, west, east, flux_res;
  logic [adf_pkg::LAMBDA_W-1:0]  lambda;

  // sequencer
  adf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_pixel_in    (in_pixel_in),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_frame_end  (out_frame_end),
    .out_run_last   (out_run_last),
    .prev_we        (prev_we),
    .prev_waddr     (prev_waddr),
    .prev_wdata     (prev_wdata),
    .prev_re        (prev_re),
    .prev_raddr     (prev_raddr),
    .prev_rdata     (prev_rdata),
    .prev2_we       (prev2_we),
    .prev2_waddr    (prev2_waddr),
    .prev2_wdata    (prev2_wdata),
    .prev2_re       (prev2_re),
    .prev2_raddr    (prev2_raddr),
    .prev2_rdata    (prev2_rdata),
    .tbl_we         (tbl_we),
    .tbl_waddr      (tbl_waddr),
    .tbl_wdata      (tbl_wdata),
    .flux_ctl       (flux_ctl),
    .cen            (cen),
    .north          (north),
    .south          (south),
    .west           (west),
    .east           (east),
    .lambda         (lambda),
    .flux_res       (flux_res)
  );

  // flux datapath
  adf_flux u_flux (
    .clk       (clk),
    .ctl       (flux_ctl),
    .cen       (cen),
    .north     (north),
    .south     (south),
    .west      (west),
    .east      (east),
    .lambda    (lambda),
    .tbl_rdata (tbl_rdata),
    .tbl_re    (tbl_re),
    .tbl_raddr (tbl_raddr),
    .res       (flux_res)
  );

  // previous row
  adf_ram #(
    .DEPTH (adf_pkg::MAX_WIDTH),
    .WIDTH (adf_pkg::PIX_W)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (prev_re),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  // row before previous
  adf_ram #(
    .DEPTH (adf_pkg::MAX_WIDTH),
    .WIDTH (adf_pkg::PIX_W)
  ) u_prev2_ram (
    .clk   (clk),
    .we    (prev2_we),
    .waddr (prev2_waddr),
    .wdata (prev2_wdata),
    .re    (prev2_re),
    .raddr (prev2_raddr),
    .rdata (prev2_rdata)
  );

  // conductance table
  adf_ram #(
    .DEPTH (adf_pkg::TBL_DEPTH),
    .WIDTH (adf_pkg::COND_W)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

endmodule

// File: design/adf_ram.sv
// simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps
module adf_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/adf_flux.sv
// flux datapath: conductance lookup, accumulate, lambda scale and clamp
`timescale 1ns / 1ps
module adf_flux (
  input  logic                                 clk,
  input  adf_pkg::flux_ctl_t                   ctl,
  input  logic [adf_pkg::PIX_W-1:0]            cen,
  input  logic [adf_pkg::PIX_W-1:0]            north,
  input  logic [adf_pkg::PIX_W-1:0]            south,
  input  logic [adf_pkg::PIX_W-1:0]            west,
  input  logic [adf_pkg::PIX_W-1:0]            east,
  input  logic [adf_pkg::LAMBDA_W-1:0]         lambda,
  input  logic [adf_pkg::COND_W-1:0]           tbl_rdata,
  output logic                                 tbl_re,
  output logic [adf_pkg::TBL_AW-1:0]           tbl_raddr,
  output logic [adf_pkg::PIX_W-1:0]            res
);

  logic        [adf_pkg::PIX_W-1:0]   nb;
  logic signed [adf_pkg::DIFF_W-1:0]  d;
  logic signed [adf_pkg::DIFF_W-1:0]  d_neg;
  logic signed [adf_pkg::DIFF_W-1:0]  d_r;
  logic signed [adf_pkg::TERM_W-1:0]  term;
  logic signed [adf_pkg::ACC_W-1:0]   acc_r;
  logic signed [adf_pkg::MPROD_W-1:0] mprod;
  logic signed [adf_pkg::MPROD_W-1:0] mprod_r;
  logic signed [adf_pkg::DELTA_W-1:0] delta;
  logic signed [adf_pkg::SUM_W-1:0]   sum;
  logic        [adf_pkg::PIX_W-1:0]   clamped;
  logic        [adf_pkg::PIX_W-1:0]   res_r;

  // neighbour select and signed difference to the centre
  always_comb begin
    case (ctl.sel)
      adf_pkg::NB_NORTH: nb = north;
      adf_pkg::NB_SOUTH: nb = south;
      adf_pkg::NB_WEST:  nb = west;
      default:           nb = east;
    endcase
  end

  assign d     = $signed({1'b0, nb}) - $signed({1'b0, cen});
  assign d_neg = -d;

  // table address is the magnitude of the difference
  assign tbl_re    = ctl.issue;
  assign tbl_raddr = d[adf_pkg::DIFF_W-1] ? d_neg[adf_pkg::TBL_AW-1:0] : d[adf_pkg::TBL_AW-1:0];

  // conductance times difference for the neighbour looked up last cycle
  assign term = $signed({1'b0, tbl_rdata}) * d_r;

  // lambda scaling of the flux sum
  assign mprod = $signed({1'b0, lambda}) * acc_r;

  // floor shift, add to the centre and clamp to pixel range
  assign delta = $signed(mprod_r[adf_pkg::MPROD_W-1:adf_pkg::SHIFT]);
  assign sum   = adf_pkg::SUM_W'($signed({1'b0, cen})) + adf_pkg::SUM_W'(delta);

  always_comb begin
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > $signed(adf_pkg::SUM_W'(adf_pkg::PIX_MAX))) begin
      clamped = adf_pkg::PIX_W'(adf_pkg::PIX_MAX);
    end else begin
      clamped = sum[adf_pkg::PIX_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      d_r <= d;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc) begin
      acc_r <= acc_r + adf_pkg::ACC_W'(term);
    end
    if (ctl.mul) begin
      mprod_r <= mprod;
    end
    if (ctl.fin) begin
      res_r <= clamped;
    end
  end

  assign res = res_r;

endmodule

// File: design/adf_ctrl.sv
// sequencer: counters, line buffer access, config registers and result register
`timescale 1ns / 1ps
`include "anisotropic_diffusion_filter_macros.svh"
module adf_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [adf_pkg::PIX_W-1:0]         in_pixel_in,
  input  logic [adf_pkg::TBL_AW-1:0]        in_table_index,
  input  logic [adf_pkg::COND_W-1:0]        in_table_value,
  // configuration
  input  logic                              cfg_we,
  input  logic [adf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adf_pkg::CFG_DATA_W-1:0]    cfg_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [adf_pkg::PIX_W-1:0]         out_pixel_out,
  output logic                              out_frame_end,
  output logic                              out_run_last,
  // previous row buffer
  output logic                              prev_we,
  output logic [adf_pkg::COL_W-1:0]         prev_waddr,
  output logic [adf_pkg::PIX_W-1:0]         prev_wdata,
  output logic                              prev_re,
  output logic [adf_pkg::COL_W-1:0]         prev_raddr,
  input  logic [adf_pkg::PIX_W-1:0]         prev_rdata,
  // row before previous buffer
  output logic                              prev2_we,
  output logic [adf_pkg::COL_W-1:0]         prev2_waddr,
  output logic [adf_pkg::PIX_W-1:0]         prev2_wdata,
  output logic                              prev2_re,
  output logic [adf_pkg::COL_W-1:0]         prev2_raddr,
  input  logic [adf_pkg::PIX_W-1:0]         prev2_rdata,
  // conductance table write
  output logic                              tbl_we,
  output logic [adf_pkg::TBL_AW-1:0]        tbl_waddr,
  output logic [adf_pkg::COND_W-1:0]        tbl_wdata,
  // flux datapath
  output adf_pkg::flux_ctl_t                flux_ctl,
  output logic [adf_pkg::PIX_W-1:0]         cen,
  output logic [adf_pkg::PIX_W-1:0]         north,
  output logic [adf_pkg::PIX_W-1:0]         south,
  output logic [adf_pkg::PIX_W-1:0]         west,
  output logic [adf_pkg::PIX_W-1:0]         east,
  output logic [adf_pkg::LAMBDA_W-1:0]      lambda,
  input  logic [adf_pkg::PIX_W-1:0]         flux_res
);

  adf_pkg::state_t state_r, state_nxt;

  logic [adf_pkg::CFG_WIDTH_W-1:0]  img_w_r;
  logic [adf_pkg::CFG_HEIGHT_W-1:0] img_h_r;
  logic [adf_pkg::LAMBDA_W-1:0]     lambda_r;
  logic [adf_pkg::COL_W-1:0]        w_m1;
  logic [adf_pkg::ROW_W-1:0]        h_m1;

  logic [adf_pkg::COL_W-1:0] col_r;
  logic [adf_pkg::ROW_W-1:0] row_r;
  logic [adf_pkg::PIX_W-1:0] ws0_r;
  logic [adf_pkg::COL_W-1:0] cur_col_r;
  logic [adf_pkg::PIX_W-1:0] pix_r;
  logic [adf_pkg::PIX_W-1:0] cen_r;
  logic [adf_pkg::PIX_W-1:0] north_r;
  logic [adf_pkg::PIX_W-1:0] west_r;
  logic                      row_zero_r;
  logic                      row_one_r;
  logic                      interior_r;
  logic                      two_r;
  logic                      col_end_r;
  logic [adf_pkg::K_W-1:0]   k_r;

  logic                      out_valid_r;
  logic [adf_pkg::PIX_W-1:0] out_pix_r;
  logic                      out_fe_r;
  logic                      out_rl_r;

  logic                      in_fire;
  logic                      pix_fire;
  logic                      tbl_fire;
  logic                      out_free;
  logic                      out_load;
  logic [adf_pkg::PIX_W-1:0] load_pix;
  logic                      load_fe;
  logic                      load_rl;

  // effective frame size, clamped to the supported range
  always_comb begin
    if (img_w_r < adf_pkg::CFG_WIDTH_W'(3)) begin
      w_m1 = adf_pkg::COL_W'(2);
    end else if (img_w_r > adf_pkg::CFG_WIDTH_W'(adf_pkg::MAX_WIDTH)) begin
      w_m1 = adf_pkg::COL_W'(adf_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1 = adf_pkg::COL_W'(img_w_r - adf_pkg::CFG_WIDTH_W'(1));
    end
    if (img_h_r < adf_pkg::CFG_HEIGHT_W'(3)) begin
      h_m1 = adf_pkg::ROW_W'(2);
    end else if (img_h_r > adf_pkg::CFG_HEIGHT_W'(adf_pkg::MAX_HEIGHT)) begin
      h_m1 = adf_pkg::ROW_W'(adf_pkg::MAX_HEIGHT - 1);
    end else begin
      h_m1 = adf_pkg::ROW_W'(img_h_r - adf_pkg::CFG_HEIGHT_W'(1));
    end
  end

  // handshakes
  assign in_ready = (state_r == adf_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pix_fire = in_fire && (in_op == adf_pkg::OP_PIXEL);
  assign tbl_fire = in_fire && (in_op == adf_pkg::OP_TABLE);
  assign out_free = !out_valid_r || out_ready;

  // table writes go straight to the table
  assign tbl_we    = tbl_fire;
  assign tbl_waddr = in_table_index;
  assign tbl_wdata = in_table_value;

  // line buffers: read centre and north at accept, shift columns and read east in fetch
  assign prev_raddr  = (state_r == adf_pkg::ST_FETCH) ?
                       adf_pkg::COL_W'(cur_col_r + 1'b1) : col_r;
  assign prev2_raddr = col_r;
  assign prev2_re    = pix_fire;
  assign prev_re     = pix_fire || (state_r == adf_pkg::ST_FETCH);
  assign prev_we     = (state_r == adf_pkg::ST_FETCH);
  assign prev_waddr  = cur_col_r;
  assign prev_wdata  = pix_r;
  assign prev2_we    = (state_r == adf_pkg::ST_FETCH);
  assign prev2_waddr = cur_col_r;
  assign prev2_wdata = prev_rdata;

  // cross taps for the flux datapath
  assign cen    = cen_r;
  assign north  = north_r;
  assign south  = pix_r;
  assign west   = west_r;
  assign east   = (cur_col_r == adf_pkg::COL_W'(adf_pkg::MAX_WIDTH - 1)) ? '0 : prev_rdata;
  assign lambda = lambda_r;

  // next state, flux sequencing and result loading
  always_comb begin
    state_nxt = state_r;
    flux_ctl  = '0;
    out_load  = 1'b0;
    load_pix  = '0;
    load_fe   = 1'b0;
    load_rl   = 1'b1;
    unique case (state_r)
      adf_pkg::ST_IDLE: begin
        if (pix_fire) begin
          state_nxt = adf_pkg::ST_FETCH;
        end
      end
      adf_pkg::ST_FETCH: begin
        flux_ctl.clr = 1'b1;
        if (row_one_r) begin
          state_nxt = adf_pkg::ST_IDLE;
        end else if (!row_zero_r && interior_r) begin
          state_nxt = adf_pkg::ST_FLUX;
        end else begin
          state_nxt = adf_pkg::ST_EMIT_A;
        end
      end
      adf_pkg::ST_FLUX: begin
        flux_ctl.issue = (k_r < adf_pkg::K_W'(adf_pkg::NB_COUNT));
        flux_ctl.sel   = adf_pkg::nb_sel_t'(k_r[1:0]);
        flux_ctl.acc   = (k_r != '0);
        if (k_r == adf_pkg::K_W'(adf_pkg::NB_COUNT)) begin
          state_nxt = adf_pkg::ST_MUL;
        end
      end
      adf_pkg::ST_MUL: begin
        flux_ctl.mul = 1'b1;
        state_nxt    = adf_pkg::ST_FIN;
      end
      adf_pkg::ST_FIN: begin
        flux_ctl.fin = 1'b1;
        state_nxt    = adf_pkg::ST_EMIT_A;
      end
      adf_pkg::ST_EMIT_A: begin
        load_pix = (!row_zero_r && interior_r) ? flux_res : '0;
        load_rl  = !two_r;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = two_r ? adf_pkg::ST_EMIT_B : adf_pkg::ST_IDLE;
        end
      end
      adf_pkg::ST_EMIT_B: begin
        load_fe = col_end_r;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = adf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = adf_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= adf_pkg::CFG_WIDTH_W'(adf_pkg::WIDTH_RESET);
      img_h_r  <= adf_pkg::CFG_HEIGHT_W'(adf_pkg::HEIGHT_RESET);
      lambda_r <= adf_pkg::LAMBDA_W'(adf_pkg::LAMBDA_RESET);
    end else if (cfg_we) begin
      unique case (adf_pkg::cfg_reg_t'(cfg_index))
        adf_pkg::REG_WIDTH:  img_w_r  <= cfg_data[adf_pkg::CFG_WIDTH_W-1:0];
        adf_pkg::REG_HEIGHT: img_h_r  <= cfg_data[adf_pkg::CFG_HEIGHT_W-1:0];
        adf_pkg::REG_LAMBDA: lambda_r <= cfg_data[adf_pkg::LAMBDA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // raster counters and west tap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ws0_r <= '0;
    end else begin
      if (pix_fire) begin
        if (col_r >= w_m1) begin
          col_r <= '0;
          row_r <= (row_r >= h_m1) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (state_r == adf_pkg::ST_FETCH) begin
        ws0_r <= col_end_r ? '0 : prev_rdata;
      end
    end
  end

  // per-pixel context captured at accept and at fetch
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      cur_col_r  <= col_r;
      pix_r      <= in_pixel_in;
      row_zero_r <= (row_r == '0);
      row_one_r  <= (row_r == adf_pkg::ROW_W'(1));
      interior_r <= (col_r != '0) && (col_r < w_m1);
      two_r      <= (row_r >= h_m1);
      col_end_r  <= (col_r >= w_m1);
    end
    if (state_r == adf_pkg::ST_FETCH) begin
      cen_r   <= prev_rdata;
      north_r <= prev2_rdata;
      west_r  <= ws0_r;
    end
  end

  // neighbour step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (state_r == adf_pkg::ST_FETCH) begin
      k_r <= '0;
    end else if (state_r == adf_pkg::ST_FLUX) begin
      k_r <= k_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r <= load_pix;
      out_fe_r  <= load_fe;
      out_rl_r  <= load_rl;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_frame_end = out_fe_r;
  assign out_run_last  = out_rl_r;

  // checks
  `ADF_ASSERT(a_fetch_after_pixel, state_r == adf_pkg::ST_FETCH, $past(pix_fire))
  `ADF_ASSERT(a_mul_after_all_nb, state_r == adf_pkg::ST_MUL, $past(state_r) == adf_pkg::ST_FLUX && $past(k_r) == adf_pkg::K_W'(adf_pkg::NB_COUNT))
  `ADF_ASSERT(a_row_one_silent, out_load, !row_one_r)
  `ADF_ASSERT_NXT(a_table_write_no_work, tbl_fire, state_r == adf_pkg::ST_IDLE)

endmodule
